// ----- hw/rtl/cpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types and constants of the circle pair collision resolver
// Fixed-point widths, pipeline depths of the root and divide units, and the
// item and context records that travel down the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpcr_pkg;

  // Square root unit: radicand below 2^51, one result bit per stage.
  localparam int D2_W       = 51;
  localparam int ROOT_W     = 26;
  localparam int SQ_STAGES  = 26;
  localparam int SQ_RW      = 52;

  // Divide unit: restoring, one quotient bit per stage.
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 26;
  localparam int DIV_Q_W    = 38;
  localparam int DIV_STAGES = 38;

  // Normal components in Q1.30.
  localparam int NRM_W      = 31;
  localparam int Q_FRAC     = 30;

  typedef struct packed {
    logic signed [31:0] pax;
    logic signed [31:0] pay;
    logic signed [31:0] qax;
    logic signed [31:0] qay;
    logic [23:0]        ra;
    logic [23:0]        ima;
    logic signed [31:0] pbx;
    logic signed [31:0] pby;
    logic signed [31:0] qbx;
    logic signed [31:0] qby;
    logic [23:0]        rb;
    logic [23:0]        imb;
  } item_t;

  typedef struct packed {
    item_t              it;
    logic               sx;
    logic               sy;
    logic [24:0]        mx;
    logic [24:0]        my;
    logic [24:0]        md;
    logic [24:0]        imt;
    logic               hit;
    logic               imp;
    logic [NRM_W-1:0]   nxm;
    logic [NRM_W-1:0]   nym;
    logic signed [31:0] npax;
    logic signed [31:0] npay;
    logic signed [31:0] npbx;
    logic signed [31:0] npby;
  } ctx_t;

endpackage

// ----- hw/rtl/cpcr_sqrt.sv -----
// ----------------------------------------------------------------------------
// cpcr_sqrt: pipelined integer square root
// floor(sqrt(rad_i)), one result bit resolved per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpcr_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [cpcr_pkg::D2_W-1:0]     rad_i,
  output logic [cpcr_pkg::ROOT_W-1:0]   root_o
);

  logic [cpcr_pkg::SQ_RW-1:0] rem_q [cpcr_pkg::SQ_STAGES];
  logic [cpcr_pkg::SQ_RW-1:0] res_q [cpcr_pkg::SQ_STAGES];

  for (genvar k = 0; k < cpcr_pkg::SQ_STAGES; k++) begin : g_stage
    logic [cpcr_pkg::SQ_RW-1:0] rem_in, res_in, rem_d, res_d, bitv, trial;

    if (k == 0) begin : g_first
      assign rem_in = cpcr_pkg::SQ_RW'(rad_i);
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    always_comb begin
      bitv  = cpcr_pkg::SQ_RW'(1) << (2 * (cpcr_pkg::SQ_STAGES - 1 - k));
      trial = res_in + bitv;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + bitv;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign root_o = res_q[cpcr_pkg::SQ_STAGES-1][cpcr_pkg::ROOT_W-1:0];

endmodule

// ----- hw/rtl/cpcr_div.sv -----
// ----------------------------------------------------------------------------
// cpcr_div: pipelined restoring divider
// Unsigned quotient of num_i by den_i, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpcr_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [cpcr_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [cpcr_pkg::DIV_DEN_W-1:0]  den_i,
  output logic [cpcr_pkg::DIV_Q_W-1:0]    quo_o
);

  logic [cpcr_pkg::DIV_NUM_W-1:0] rem_q [cpcr_pkg::DIV_STAGES];
  logic [cpcr_pkg::DIV_DEN_W-1:0] den_q [cpcr_pkg::DIV_STAGES];
  logic [cpcr_pkg::DIV_Q_W-1:0]   quo_q [cpcr_pkg::DIV_STAGES];

  for (genvar i = 0; i < cpcr_pkg::DIV_STAGES; i++) begin : g_stage
    logic [cpcr_pkg::DIV_NUM_W-1:0] rem_in, rem_d, shd;
    logic [cpcr_pkg::DIV_DEN_W-1:0] den_in;
    logic [cpcr_pkg::DIV_Q_W-1:0]   quo_in, quo_d;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // Trial subtract of the divisor aligned to this quotient bit.
    always_comb begin
      shd   = cpcr_pkg::DIV_NUM_W'(den_in) << (cpcr_pkg::DIV_Q_W - 1 - i);
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= shd) begin
        rem_d = rem_in - shd;
        quo_d[cpcr_pkg::DIV_Q_W-1-i] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        den_q[i] <= den_in;
        quo_q[i] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[cpcr_pkg::DIV_STAGES-1];

endmodule

// ----- hw/rtl/circle_pair_collision_resolve_top.sv -----
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_top: Verlet circle pair collision resolver
// Separates two overlapping circles along their normal by inverse mass and
// applies an elastic impulse by rewriting the previous positions.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one pair per beat on the s_axis channel (both bodies, Q16.16
//   positions, Q8.16 radius and inverse mass). One result beat leaves on the
//   m_axis channel per input beat, in order: four updated positions and four
//   rewritten previous positions in tdata, the collided and impulse flags in
//   tuser.
//   Throughput: one pair per cycle while m_axis_tready_i does not stall the
//   pipeline. Every stage is a register, so a new beat is taken each cycle
//   while earlier pairs are still in flight.
//   Depth: 112 register stages: the 26-stage square root, two 38-stage
//   dividers in series (normal and overlap share, then impulse share), plus
//   ten stages of capture, compare, multiply and saturate.
//   Reset clears every valid bit; the pipeline then holds no beat.
//   Stall: while a result beat waits on m_axis_tready_i, the whole pipeline
//   holds and s_axis_tready_o drops; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_pair_collision_resolve_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pos_a_x[31:0] pos_a_y[63:32] prev_a_x[95:64] prev_a_y[127:96]
  // radius_a[151:128] inv_mass_a[175:152] pos_b_x[207:176] pos_b_y[239:208]
  // prev_b_x[271:240] prev_b_y[303:272] radius_b[327:304] inv_mass_b[351:328]
  input  logic [351:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // new_pos_a_x[31:0] new_pos_a_y[63:32] new_prev_a_x[95:64]
  // new_prev_a_y[127:96] new_pos_b_x[159:128] new_pos_b_y[191:160]
  // new_prev_b_x[223:192] new_prev_b_y[255:224]
  output logic [255:0] m_axis_tdata_o,
  // collided[0] impulse_applied[1]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int SQ  = cpcr_pkg::SQ_STAGES;
  localparam int DV  = cpcr_pkg::DIV_STAGES;

  // Clamp to the signed 32 bit range.
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -42'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Velocity p - q, exact.
  function automatic logic signed [32:0] vel(input logic signed [31:0] p,
                                             input logic signed [31:0] q);
    return $signed({p[31], p}) - $signed({q[31], q});
  endfunction

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Valid bits, one per stage.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, vo_q;
  logic vs_q [SQ];
  logic vd_q [DV];
  logic vk_q [DV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; vo_q <= 1'b0;
      for (int i = 0; i < SQ; i++) vs_q[i] <= 1'b0;
      for (int i = 0; i < DV; i++) begin
        vd_q[i] <= 1'b0;
        vk_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vs_q[0] <= v4_q;
      for (int i = 1; i < SQ; i++) vs_q[i] <= vs_q[i-1];
      v5_q <= vs_q[SQ-1];
      vd_q[0] <= v5_q;
      for (int i = 1; i < DV; i++) vd_q[i] <= vd_q[i-1];
      v6_q <= vd_q[DV-1];
      v7_q <= v6_q;
      v8_q <= v7_q;
      vk_q[0] <= v8_q;
      for (int i = 1; i < DV; i++) vk_q[i] <= vk_q[i-1];
      v9_q <= vk_q[DV-1];
      vo_q <= v9_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the beat
  // --------------------------------------------------------------------------
  cpcr_pkg::item_t in_it, it1_q;

  assign in_it.pax = s_axis_tdata_i[31:0];
  assign in_it.pay = s_axis_tdata_i[63:32];
  assign in_it.qax = s_axis_tdata_i[95:64];
  assign in_it.qay = s_axis_tdata_i[127:96];
  assign in_it.ra  = s_axis_tdata_i[151:128];
  assign in_it.ima = s_axis_tdata_i[175:152];
  assign in_it.pbx = s_axis_tdata_i[207:176];
  assign in_it.pby = s_axis_tdata_i[239:208];
  assign in_it.qbx = s_axis_tdata_i[271:240];
  assign in_it.qby = s_axis_tdata_i[303:272];
  assign in_it.rb  = s_axis_tdata_i[327:304];
  assign in_it.imb = s_axis_tdata_i[351:328];

  always_ff @(posedge clk_i) begin
    if (en) it1_q <= in_it;
  end

  // --------------------------------------------------------------------------
  // Stage 2: center delta, radius sum, bounding-box reject
  // --------------------------------------------------------------------------
  logic signed [32:0] dx1, dy1;
  logic [32:0]        mx1, my1;
  logic [24:0]        md1, imt1;
  logic               ok1;
  cpcr_pkg::ctx_t     ctx2_d, ctx2_q;

  always_comb begin
    dx1  = $signed({it1_q.pax[31], it1_q.pax}) - $signed({it1_q.pbx[31], it1_q.pbx});
    dy1  = $signed({it1_q.pay[31], it1_q.pay}) - $signed({it1_q.pby[31], it1_q.pby});
    mx1  = dx1[32] ? $unsigned(-dx1) : $unsigned(dx1);
    my1  = dy1[32] ? $unsigned(-dy1) : $unsigned(dy1);
    md1  = 25'(it1_q.ra) + 25'(it1_q.rb);
    imt1 = 25'(it1_q.ima) + 25'(it1_q.imb);
    ok1  = (mx1 < 33'(md1)) && (my1 < 33'(md1)) && (imt1 != '0);

    ctx2_d     = '0;
    ctx2_d.it  = it1_q;
    ctx2_d.sx  = dx1[32];
    ctx2_d.sy  = dy1[32];
    ctx2_d.mx  = ok1 ? mx1[24:0] : '0;
    ctx2_d.my  = ok1 ? my1[24:0] : '0;
    ctx2_d.md  = md1;
    ctx2_d.imt = imt1;
    ctx2_d.hit = ok1;
  end

  always_ff @(posedge clk_i) begin
    if (en) ctx2_q <= ctx2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares
  // --------------------------------------------------------------------------
  logic [49:0]    sqx3_q, sqy3_q, mdsq3_q;
  cpcr_pkg::ctx_t ctx3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx3_q  <= ctx2_q;
      sqx3_q  <= ctx2_q.mx * ctx2_q.mx;
      sqy3_q  <= ctx2_q.my * ctx2_q.my;
      mdsq3_q <= ctx2_q.md * ctx2_q.md;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: exact overlap test; distance squared feeds the root unit
  // --------------------------------------------------------------------------
  logic [cpcr_pkg::D2_W-1:0] d23, d24_q;
  cpcr_pkg::ctx_t            ctx4_d, ctx4_q;

  always_comb begin
    d23        = cpcr_pkg::D2_W'(sqx3_q) + cpcr_pkg::D2_W'(sqy3_q);
    ctx4_d     = ctx3_q;
    ctx4_d.hit = ctx3_q.hit && (d23 != '0) && (d23 < cpcr_pkg::D2_W'(mdsq3_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx4_q <= ctx4_d;
      d24_q  <= d23;
    end
  end

  logic [cpcr_pkg::ROOT_W-1:0] root;
  cpcr_pkg::ctx_t              ctxs_q [SQ];

  cpcr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (d24_q),
    .root_o (root)
  );

  // Hold the item context alongside the root unit.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctxs_q[0] <= ctx4_q;
      for (int i = 1; i < SQ; i++) ctxs_q[i] <= ctxs_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: overlap and share numerators
  // --------------------------------------------------------------------------
  logic [24:0]                 ov5;
  logic [48:0]                 pa5_q, pb5_q;
  logic [cpcr_pkg::ROOT_W-1:0] dist5_q;
  cpcr_pkg::ctx_t              ctx5_q;

  assign ov5 = ctxs_q[SQ-1].md - root[24:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx5_q  <= ctxs_q[SQ-1];
      dist5_q <= root;
      pa5_q   <= ov5 * ctxs_q[SQ-1].it.ima;
      pb5_q   <= ov5 * ctxs_q[SQ-1].it.imb;
    end
  end

  // Normal components and overlap shares, in parallel.
  logic [cpcr_pkg::DIV_Q_W-1:0] qnx, qny, qca, qcb;
  cpcr_pkg::ctx_t               ctxd_q [DV];

  cpcr_div u_div_nx (
    .clk_i (clk_i), .en_i (en),
    .num_i (cpcr_pkg::DIV_NUM_W'(ctx5_q.mx) << cpcr_pkg::Q_FRAC),
    .den_i (dist5_q), .quo_o (qnx)
  );
  cpcr_div u_div_ny (
    .clk_i (clk_i), .en_i (en),
    .num_i (cpcr_pkg::DIV_NUM_W'(ctx5_q.my) << cpcr_pkg::Q_FRAC),
    .den_i (dist5_q), .quo_o (qny)
  );
  cpcr_div u_div_ca (
    .clk_i (clk_i), .en_i (en),
    .num_i (cpcr_pkg::DIV_NUM_W'(pa5_q)),
    .den_i (cpcr_pkg::DIV_DEN_W'(ctx5_q.imt)), .quo_o (qca)
  );
  cpcr_div u_div_cb (
    .clk_i (clk_i), .en_i (en),
    .num_i (cpcr_pkg::DIV_NUM_W'(pb5_q)),
    .den_i (cpcr_pkg::DIV_DEN_W'(ctx5_q.imt)), .quo_o (qcb)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctxd_q[0] <= ctx5_q;
      for (int i = 1; i < DV; i++) ctxd_q[i] <= ctxd_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: displacement and approach-speed products
  // --------------------------------------------------------------------------
  cpcr_pkg::ctx_t     ctx6_d, ctx6_q;
  logic signed [33:0] rvx6, rvy6;
  logic [33:0]        mrx6, mry6;
  logic [55:0]        pdax_q, pday_q, pdbx_q, pdby_q;
  logic [34:0]        phx_q, phy_q;
  logic [60:0]        plx_q, ply_q;
  logic               svx_q, svy_q;

  always_comb begin
    logic signed [32:0] vax, vay, vbx, vby;
    vax  = vel(ctxd_q[DV-1].it.pax, ctxd_q[DV-1].it.qax);
    vay  = vel(ctxd_q[DV-1].it.pay, ctxd_q[DV-1].it.qay);
    vbx  = vel(ctxd_q[DV-1].it.pbx, ctxd_q[DV-1].it.qbx);
    vby  = vel(ctxd_q[DV-1].it.pby, ctxd_q[DV-1].it.qby);
    rvx6 = $signed({vax[32], vax}) - $signed({vbx[32], vbx});
    rvy6 = $signed({vay[32], vay}) - $signed({vby[32], vby});
    mrx6 = rvx6[33] ? $unsigned(-rvx6) : $unsigned(rvx6);
    mry6 = rvy6[33] ? $unsigned(-rvy6) : $unsigned(rvy6);
    ctx6_d     = ctxd_q[DV-1];
    ctx6_d.nxm = qnx[cpcr_pkg::NRM_W-1:0];
    ctx6_d.nym = qny[cpcr_pkg::NRM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx6_q <= ctx6_d;
      pdax_q <= qca[24:0] * ctx6_d.nxm;
      pday_q <= qca[24:0] * ctx6_d.nym;
      pdbx_q <= qcb[24:0] * ctx6_d.nxm;
      pdby_q <= qcb[24:0] * ctx6_d.nym;
      phx_q  <= mrx6[33:30] * ctx6_d.nxm;
      phy_q  <= mry6[33:30] * ctx6_d.nym;
      plx_q  <= mrx6[29:0] * ctx6_d.nxm;
      ply_q  <= mry6[29:0] * ctx6_d.nym;
      svx_q  <= rvx6[33];
      svy_q  <= rvy6[33];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: corrected positions, normal approach speed
  // --------------------------------------------------------------------------
  cpcr_pkg::ctx_t     ctx7_d, ctx7_q;
  logic signed [37:0] vn7_d, vn7_q;

  always_comb begin
    logic [25:0]        dax, day, dbx, dby;
    logic signed [33:0] sax, say, sbx, sby;
    logic [35:0]        tx, ty;
    logic signed [37:0] vnx, vny;
    cpcr_pkg::item_t    it;
    it  = ctx6_q.it;
    dax = pdax_q[55:30];
    day = pday_q[55:30];
    dbx = pdbx_q[55:30];
    dby = pdby_q[55:30];
    // A moves along +n, B along -n.
    sax = ctx6_q.sx ? $signed({{2{it.pax[31]}}, it.pax}) - $signed({8'd0, dax})
                    : $signed({{2{it.pax[31]}}, it.pax}) + $signed({8'd0, dax});
    say = ctx6_q.sy ? $signed({{2{it.pay[31]}}, it.pay}) - $signed({8'd0, day})
                    : $signed({{2{it.pay[31]}}, it.pay}) + $signed({8'd0, day});
    sbx = ctx6_q.sx ? $signed({{2{it.pbx[31]}}, it.pbx}) + $signed({8'd0, dbx})
                    : $signed({{2{it.pbx[31]}}, it.pbx}) - $signed({8'd0, dbx});
    sby = ctx6_q.sy ? $signed({{2{it.pby[31]}}, it.pby}) + $signed({8'd0, dby})
                    : $signed({{2{it.pby[31]}}, it.pby}) - $signed({8'd0, dby});

    tx  = {1'b0, phx_q} + {5'd0, plx_q[60:30]};
    ty  = {1'b0, phy_q} + {5'd0, ply_q[60:30]};
    vnx = (svx_q != ctx6_q.sx) ? -$signed({2'b0, tx}) : $signed({2'b0, tx});
    vny = (svy_q != ctx6_q.sy) ? -$signed({2'b0, ty}) : $signed({2'b0, ty});
    vn7_d = vnx + vny;

    ctx7_d      = ctx6_q;
    ctx7_d.npax = ctx6_q.hit ? sat32(42'(sax)) : it.pax;
    ctx7_d.npay = ctx6_q.hit ? sat32(42'(say)) : it.pay;
    ctx7_d.npbx = ctx6_q.hit ? sat32(42'(sbx)) : it.pbx;
    ctx7_d.npby = ctx6_q.hit ? sat32(42'(sby)) : it.pby;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx7_q <= ctx7_d;
      vn7_q  <= vn7_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: approach decision and impulse share numerators
  // --------------------------------------------------------------------------
  cpcr_pkg::ctx_t ctx8_d, ctx8_q;
  logic [37:0]    avn8, av28;
  logic [61:0]    kan_q, kbn_q;

  always_comb begin
    avn8       = $unsigned(-vn7_q);
    av28       = {avn8[36:0], 1'b0};
    ctx8_d     = ctx7_q;
    ctx8_d.imp = ctx7_q.hit && vn7_q[37];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx8_q <= ctx8_d;
      kan_q  <= av28 * ctx7_q.it.ima;
      kbn_q  <= av28 * ctx7_q.it.imb;
    end
  end

  logic [cpcr_pkg::DIV_Q_W-1:0] qka, qkb;
  cpcr_pkg::ctx_t               ctxk_q [DV];

  cpcr_div u_div_ka (
    .clk_i (clk_i), .en_i (en),
    .num_i (cpcr_pkg::DIV_NUM_W'(kan_q)),
    .den_i (cpcr_pkg::DIV_DEN_W'(ctx8_q.imt)), .quo_o (qka)
  );
  cpcr_div u_div_kb (
    .clk_i (clk_i), .en_i (en),
    .num_i (cpcr_pkg::DIV_NUM_W'(kbn_q)),
    .den_i (cpcr_pkg::DIV_DEN_W'(ctx8_q.imt)), .quo_o (qkb)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctxk_q[0] <= ctx8_q;
      for (int i = 1; i < DV; i++) ctxk_q[i] <= ctxk_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: velocity change products, split at the Q30 point
  // --------------------------------------------------------------------------
  cpcr_pkg::ctx_t ctx9_q;
  logic [38:0]    hkax_q, hkay_q, hkbx_q, hkby_q;
  logic [60:0]    lkax_q, lkay_q, lkbx_q, lkby_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx9_q <= ctxk_q[DV-1];
      hkax_q <= qka[37:30] * ctxk_q[DV-1].nxm;
      hkay_q <= qka[37:30] * ctxk_q[DV-1].nym;
      hkbx_q <= qkb[37:30] * ctxk_q[DV-1].nxm;
      hkby_q <= qkb[37:30] * ctxk_q[DV-1].nym;
      lkax_q <= qka[29:0] * ctxk_q[DV-1].nxm;
      lkay_q <= qka[29:0] * ctxk_q[DV-1].nym;
      lkbx_q <= qkb[29:0] * ctxk_q[DV-1].nxm;
      lkby_q <= qkb[29:0] * ctxk_q[DV-1].nym;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: rewritten previous positions into the output register
  // --------------------------------------------------------------------------
  logic signed [31:0] nqax, nqay, nqbx, nqby;

  always_comb begin
    logic [38:0]        dvax, dvay, dvbx, dvby;
    logic signed [41:0] sax, say, sbx, sby;
    logic signed [32:0] vax, vay, vbx, vby;
    cpcr_pkg::item_t    it;
    it   = ctx9_q.it;
    dvax = hkax_q + {8'd0, lkax_q[60:30]};
    dvay = hkay_q + {8'd0, lkay_q[60:30]};
    dvbx = hkbx_q + {8'd0, lkbx_q[60:30]};
    dvby = hkby_q + {8'd0, lkby_q[60:30]};
    sax  = ctx9_q.sx ? -$signed({3'b0, dvax}) : $signed({3'b0, dvax});
    say  = ctx9_q.sy ? -$signed({3'b0, dvay}) : $signed({3'b0, dvay});
    sbx  = ctx9_q.sx ? -$signed({3'b0, dvbx}) : $signed({3'b0, dvbx});
    sby  = ctx9_q.sy ? -$signed({3'b0, dvby}) : $signed({3'b0, dvby});
    vax  = vel(it.pax, it.qax);
    vay  = vel(it.pay, it.qay);
    vbx  = vel(it.pbx, it.qbx);
    vby  = vel(it.pby, it.qby);
    nqax = it.qax;
    nqay = it.qay;
    nqbx = it.qbx;
    nqby = it.qby;
    if (ctx9_q.imp) begin
      nqax = sat32(42'(ctx9_q.npax) - (42'(vax) + sax));
      nqay = sat32(42'(ctx9_q.npay) - (42'(vay) + say));
      nqbx = sat32(42'(ctx9_q.npbx) - (42'(vbx) - sbx));
      nqby = sat32(42'(ctx9_q.npby) - (42'(vby) - sby));
    end
  end

  logic [255:0] tdata_q;
  logic [1:0]   tuser_q;

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {nqby, nqbx, ctx9_q.npby, ctx9_q.npbx,
                  nqay, nqax, ctx9_q.npay, ctx9_q.npax};
      tuser_q <= {ctx9_q.imp, ctx9_q.hit};
    end
  end

  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;
  assign m_axis_tvalid_o = vo_q;

endmodule

// ----- tb/tb_circle_pair_collision_resolve_top.sv -----
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_resolve_top: regression for the circle pair resolver
// Drives circle pairs on the input stream and checks every output beat, field
// by field and in order, against a behavioral resolver kept in the bench.
// Covers directed corner pairs, then random contacts and raw noise under
// three backpressure mixes, with one full drain in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circle_pair_collision_resolve_top;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 150;   // beyond the 112-stage pipeline depth
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam logic [63:0] Q30_MASK = 64'h3FFF_FFFF;

  typedef struct {
    logic signed [31:0] pax, pay, qax, qay, pbx, pby, qbx, qby;
    logic               collided;
    logic               impulse;
  } outcome_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [351:0] s_axis_tdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [255:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;

  outcome_t pending_outcomes[$];
  logic     pair_taken = 1'b0;   // set at the edge that took the driven pair
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  circle_pair_collision_resolve_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- resolver

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // trunc(+/- a * b / 2^30), a below 2^40, b at most 2^30
  function automatic longint scale_q30(logic neg, logic [63:0] a, logic [63:0] b);
    logic [63:0] m;
    m = (a >> 30) * b + (((a & Q30_MASK) * b) >> 30);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic outcome_t resolve_pair(cpcr_pkg::item_t p);
    outcome_t    r;
    longint      dx, dy, vax, vay, vbx, vby, rvx, rvy, vn;
    longint      npax, npay, npbx, npby;
    logic [63:0] mx, my, md, imt, d2, dist_len, nxm, nym, ov, ca, cb, av2, ka, kb;
    logic        nxs, nys;
    r = '{p.pax, p.pay, p.qax, p.qay, p.pbx, p.pby, p.qbx, p.qby, 1'b0, 1'b0};
    dx  = longint'(p.pax) - longint'(p.pbx);
    dy  = longint'(p.pay) - longint'(p.pby);
    mx  = magnitude(dx);
    my  = magnitude(dy);
    md  = 64'(p.ra) + 64'(p.rb);
    imt = 64'(p.ima) + 64'(p.imb);
    if (!(mx < md && my < md && imt != 0)) return r;
    d2 = mx * mx + my * my;
    // coincident centres have no normal: pass through
    if (d2 == 0 || d2 >= md * md) return r;
    dist_len = floor_sqrt(d2);
    nxm  = (mx << 30) / dist_len;
    nym  = (my << 30) / dist_len;
    nxs  = dx < 0;
    nys  = dy < 0;
    ov   = md - dist_len;
    ca   = ov * 64'(p.ima) / imt;
    cb   = ov * 64'(p.imb) / imt;
    npax = clamp32(longint'(p.pax) + scale_q30(nxs, ca, nxm));
    npay = clamp32(longint'(p.pay) + scale_q30(nys, ca, nym));
    npbx = clamp32(longint'(p.pbx) - scale_q30(nxs, cb, nxm));
    npby = clamp32(longint'(p.pby) - scale_q30(nys, cb, nym));
    r.pax = npax;  r.pay = npay;  r.pbx = npbx;  r.pby = npby;
    r.collided = 1'b1;
    vax = longint'(p.pax) - longint'(p.qax);
    vay = longint'(p.pay) - longint'(p.qay);
    vbx = longint'(p.pbx) - longint'(p.qbx);
    vby = longint'(p.pby) - longint'(p.qby);
    rvx = vax - vbx;
    rvy = vay - vby;
    vn  = scale_q30((rvx < 0) != nxs, magnitude(rvx), nxm)
        + scale_q30((rvy < 0) != nys, magnitude(rvy), nym);
    // a tiny approach that truncates to zero is not an approach
    if (vn < 0) begin
      av2 = magnitude(vn) * 2;
      ka  = av2 * 64'(p.ima) / imt;
      kb  = av2 * 64'(p.imb) / imt;
      r.impulse = 1'b1;
      r.qax = clamp32(npax - (vax + scale_q30(nxs, ka, nxm)));
      r.qay = clamp32(npay - (vay + scale_q30(nys, ka, nym)));
      r.qbx = clamp32(npbx - (vbx - scale_q30(nxs, kb, nxm)));
      r.qby = clamp32(npby - (vby - scale_q30(nys, kb, nym)));
    end
    return r;
  endfunction

  // pos_a_x sits in the lowest bits, inv_mass_b in the highest
  function automatic logic [351:0] pack_pair(cpcr_pkg::item_t p);
    return {p.imb, p.rb, p.qby, p.qbx, p.pby, p.pbx,
            p.ima, p.ra, p.qay, p.qax, p.pay, p.pax};
  endfunction

  function automatic cpcr_pkg::item_t unpack_pair(logic [351:0] d);
    cpcr_pkg::item_t p;
    {p.imb, p.rb, p.qby, p.qbx, p.pby, p.pbx,
     p.ima, p.ra, p.qay, p.qax, p.pay, p.pax} = d;
    return p;
  endfunction

  // ----------------------------------------------------------------- monitor

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  // Record accepted pairs and score output beats at the same edge.
  always @(posedge clk_i) begin
    outcome_t want;
    pair_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      pending_outcomes.push_back(resolve_pair(unpack_pair(s_axis_tdata_i)));
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("output beat with no pair outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("new_pos_a_x",  want.pax, m_axis_tdata_o[31:0]);
        check_field("new_pos_a_y",  want.pay, m_axis_tdata_o[63:32]);
        check_field("new_prev_a_x", want.qax, m_axis_tdata_o[95:64]);
        check_field("new_prev_a_y", want.qay, m_axis_tdata_o[127:96]);
        check_field("new_pos_b_x",  want.pbx, m_axis_tdata_o[159:128]);
        check_field("new_pos_b_y",  want.pby, m_axis_tdata_o[191:160]);
        check_field("new_prev_b_x", want.qbx, m_axis_tdata_o[223:192]);
        check_field("new_prev_b_y", want.qby, m_axis_tdata_o[255:224]);
        check_field("collided",        want.collided, m_axis_tuser_o[0]);
        check_field("impulse_applied", want.impulse,  m_axis_tuser_o[1]);
      end
    end
  end

  // Random backpressure on the result side.
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus

  // Drive one pair; called and returning at a falling edge.
  task automatic send_pair(cpcr_pkg::item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i  = pack_pair(p);
    s_axis_tvalid_i = 1'b1;
    do @(negedge clk_i); while (!pair_taken);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_s32();
    return $urandom();
  endfunction

  function automatic logic signed [31:0] offset_clamped(logic signed [31:0] base, longint off);
    longint v;
    v = longint'(base) - off;
    if (v > S32_MAX || v < S32_MIN) v = longint'(base) + off;
    return clamp32(v);
  endfunction

  function automatic longint rand_offset(int span);
    longint m;
    m = (span <= 0) ? 0 : longint'($urandom_range(span));
    return $urandom_range(1) ? -m : m;
  endfunction

  // Nearby pair with random velocities, centres within 3/4 of the radius sum on each axis; mass and reach vary widely.
  function automatic cpcr_pkg::item_t make_contact();
    cpcr_pkg::item_t p;
    int              reach, vel;
    p.ra  = $urandom_range(7) == 0 ? 24'($urandom()) : 24'($urandom_range(1 << 20));
    p.rb  = $urandom_range(7) == 0 ? 24'($urandom()) : 24'($urandom_range(1 << 20));
    p.ima = $urandom_range(9) == 0 ? 24'd0 : 24'($urandom());
    p.imb = $urandom_range(9) == 0 ? 24'd0 : 24'($urandom());
    p.pax = $urandom_range(9) == 0 ? rand_s32()
                                   : 32'(rand_offset(1 << 28));
    p.pay = $urandom_range(9) == 0 ? rand_s32()
                                   : 32'(rand_offset(1 << 28));
    reach = (int'(p.ra) + int'(p.rb)) * 3 / 4;
    p.pbx = offset_clamped(p.pax, rand_offset(reach));
    p.pby = offset_clamped(p.pay, rand_offset(reach));
    vel = $urandom_range(3) == 0 ? (1 << 24) : (1 << 17);
    p.qax = offset_clamped(p.pax, rand_offset(vel));
    p.qay = offset_clamped(p.pay, rand_offset(vel));
    p.qbx = offset_clamped(p.pbx, rand_offset(vel));
    p.qby = offset_clamped(p.pby, rand_offset(vel));
    return p;
  endfunction

  function automatic cpcr_pkg::item_t make_noise();
    return unpack_pair({$urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom()});
  endfunction

  function automatic cpcr_pkg::item_t pair_of(int ax, int ay, int bx, int by, int r,
                                              int ima, int imb, int vax, int vbx);
    cpcr_pkg::item_t p;
    p = '{pax: ax, pay: ay, qax: ax - vax, qay: ay, ra: 24'(r), ima: 24'(ima),
          pbx: bx, pby: by, qbx: bx - vbx, qby: by, rb: 24'(r), imb: 24'(imb)};
    return p;
  endfunction

  task automatic test_directed();
    cpcr_pkg::item_t p;
    localparam int ONE = 1 << 16;
    send_idle_pct = 25;
    recv_idle_pct = 55;
    // field extremes: all zeros, all ones
    send_pair(unpack_pair('0));
    send_pair(unpack_pair('1));
    // far apart, no overlap
    send_pair(pair_of(0, 0, 100 * ONE, 0, ONE, ONE, ONE, ONE, 0));
    // centres coincide
    send_pair(pair_of(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, ONE, ONE, ONE, ONE, -ONE));
    // radius sum zero
    send_pair(pair_of(0, 0, 1, 0, 0, ONE, ONE, 1, 0));
    // both immovable
    send_pair(pair_of(0, 0, ONE, 0, ONE, 0, 0, ONE, -ONE));
    // oblique approach, equal masses
    send_pair(pair_of(0, 0, ONE, ONE / 2, ONE, ONE, ONE, ONE / 4, -ONE / 4));
    // overlapping but separating
    send_pair(pair_of(0, 0, ONE, 0, ONE, ONE, ONE, -ONE / 4, ONE / 4));
    // one immovable body
    send_pair(pair_of(0, 0, ONE, -ONE / 3, ONE, 0, 2 * ONE, ONE / 8, 0));
    // slight separation that rounds to zero
    send_pair(pair_of(0, 0, ONE, ONE / 3, ONE, ONE, ONE, 0, 1));
    // push past the top of the coordinate range
    send_pair(pair_of(32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_0000, 32'h7FFF_0000,
                      24'hFF_FFFF, 24'hFF_FFFF, 24'h1, -(1 << 23), 1 << 23));
    // and past the bottom
    send_pair(pair_of(32'h8000_0010, 32'h8000_0010, 32'h8001_0000, 32'h8001_0000,
                      24'hFF_FFFF, 24'h1, 24'hFF_FFFF, 1 << 23, -(1 << 23)));
    // largest radii and masses, tiny offset
    send_pair(pair_of(0, 0, 1, -1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1 << 24,
                      -(1 << 24)));
    // diagonal hit in the negative quadrant
    p = pair_of(-ONE, -ONE, 0, 0, ONE, ONE / 2, 3 * ONE, -ONE / 2, ONE / 2);
    p.qay = p.pay + ONE / 2;
    send_pair(p);
  endtask

  task automatic test_random(int count, int snd_pct, int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) begin
      // mostly real contacts; the rest is noise that rarely touches
      send_pair($urandom_range(99) < 80 ? make_contact() : make_noise());
    end
  endtask

  // Hold the input until the pipeline has fully drained, then resume.
  task automatic test_drain_and_resume();
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    test_random(20, 0, 0);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(140, 25, 55);
    test_random(140, 55, 25);
    test_drain_and_resume();
    test_random(140, 0, 0);
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- circle_pair_collision_resolve_top.f -----
hw/rtl/cpcr_pkg.sv
hw/rtl/cpcr_sqrt.sv
hw/rtl/cpcr_div.sv
hw/rtl/circle_pair_collision_resolve_top.sv
tb/tb_circle_pair_collision_resolve_top.sv
